FILE: hw/rtl/double_ended_queue_defines.svh
// Assertion macros used by the deque datapath.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dq_pkg.sv
package dq_pkg;

  localparam int unsigned DEPTH_DEF     = 8;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned OCC_W    = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LOAD = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_out;
  } ctrl_t;

endpackage

FILE: hw/rtl/double_ended_queue.sv
// Double-ended queue of signed words, DEPTH entries deep, held in a circular
// buffer with a head pointer and a fill count.
// Input channel: cmd_i (0 push front, 1 push back, 2 pop front, 3 pop back) and
// push_value_i, taken when in_valid_i is high and in_stall_o is low.
// Output channel: one item per command with status_o (0 done, 1 full,
// 2 empty), popped_value_o (zero unless a pop succeeded) and occupancy_o,
// taken when out_valid_o is high and out_stall_i is low.
// A refused push or pop leaves the contents, pointer and count unchanged.
// A taken command is captured in the in-flight registers, with the slot memory
// read, and moves to the output register when that is empty or being drained;
// the two-state controller takes no new command until the last one has moved.
// While the receiver stalls, one finished result waits in the output register
// and one more command is still taken and held; after that in_stall_o stays
// high until the output register drains.
// Reset empties the deque at once: head and count clear, no clearing pass.
module double_ended_queue #(
  parameter int unsigned DEPTH     = dq_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [dq_pkg::CMD_W-1:0]          cmd_i,
  input  logic signed [dq_pkg::VALUE_W-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [dq_pkg::STATUS_W-1:0]       status_o,
  output logic signed [dq_pkg::VALUE_W-1:0] popped_value_o,
  output logic [dq_pkg::OCC_W-1:0]          occupancy_o
);
  import dq_pkg::*;

  ctrl_t ctrl;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ctrl_o     (ctrl)
  );

  dq_datapath #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cmd_i         (cmd_i),
    .push_value_i  (push_value_i),
    .status_o      (status_o),
    .popped_value_o(popped_value_o),
    .occupancy_o   (occupancy_o)
  );

endmodule

FILE: hw/rtl/dq_ram.sv
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/dq_ctrl.sv
module dq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dq_pkg::ctrl_t ctrl_o
);
  import dq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   load_out;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    accept     = in_valid_i && (state_q == S_IDLE);
    // The output register takes a result when it is empty or being drained.
    load_out   = (state_q == S_LOAD) && (!out_valid_q || !out_stall_i);
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ctrl_o      = '{accept: accept, load_out: load_out};

endmodule

FILE: hw/rtl/dq_datapath.sv
`include "double_ended_queue_defines.svh"

module dq_datapath #(
  parameter int unsigned DEPTH     = dq_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = dq_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dq_pkg::ctrl_t                 ctrl_i,
  input  logic [dq_pkg::CMD_W-1:0]      cmd_i,
  input  logic signed [dq_pkg::VALUE_W-1:0] push_value_i,
  output logic [dq_pkg::STATUS_W-1:0]   status_o,
  output logic signed [dq_pkg::VALUE_W-1:0] popped_value_o,
  output logic [dq_pkg::OCC_W-1:0]      occupancy_o
);
  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  status_e       status_q, status_d;
  logic          pop_ok_q, pop_ok_d;
  logic [CW-1:0] occ_q;

  logic [STATUS_W-1:0]     out_status_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [OCC_W-1:0]        out_occ_q;

  cmd_e             cmd;
  logic             full, empty;
  logic [AW-1:0]    head_prev, head_next, back_free, back_last;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;

  // Position head + off, wrapped once; correct for off up to DEPTH.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + (AW + 1)'(off);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign cmd       = cmd_e'(cmd_i);
  assign full      = (count_q == DEPTH_C);
  assign empty     = (count_q == '0);
  assign head_prev = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
  assign head_next = wrap_add(head_q, CW'(1));
  assign back_free = wrap_add(head_q, count_q);
  assign back_last = wrap_add(head_q, count_q - 1'b1);
  assign wdata     = WORD_BITS'(push_value_i);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = ST_DONE;
    pop_ok_d = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = back_free;
    raddr    = head_q;
    unique case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we      = ctrl_i.accept;
          waddr   = head_prev;
          head_d  = head_prev;
          count_d = count_q + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          we      = ctrl_i.accept;
          waddr   = back_free;
          count_d = count_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          re       = ctrl_i.accept;
          raddr    = head_q;
          pop_ok_d = 1'b1;
          head_d   = head_next;
          count_d  = count_q - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          re       = ctrl_i.accept;
          raddr    = back_last;
          pop_ok_d = 1'b1;
          count_d  = count_q - 1'b1;
        end
      end
      default: status_d = ST_DONE;
    endcase
  end

  dq_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (ctrl_i.accept) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Result of the item in flight; the read data lands while it waits.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
      occ_q    <= count_d;
    end
    if (ctrl_i.load_out) begin
      out_status_q <= status_q;
      out_value_q  <= pop_ok_q ? VALUE_W'($signed(rdata)) : '0;
      out_occ_q    <= OCC_W'(occ_q);
    end
  end

  assign status_o       = out_status_q;
  assign popped_value_o = out_value_q;
  assign occupancy_o    = out_occ_q;

  `DQ_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= DEPTH_C,
                  "deque count exceeds depth")
  `DQ_ASSERT_NEXT(a_refused_keeps_state, clk_i, rst_ni,
                  ctrl_i.accept && (status_d != ST_DONE),
                  (count_q == $past(count_q)) && (head_q == $past(head_q)),
                  "refused command changed the deque state")
  `DQ_ASSERT_SAME(a_no_write_and_read, clk_i, rst_ni, we, !re,
                  "one command both wrote and read the slot memory")
  `DQ_ASSERT_NEXT(a_pop_on_empty, clk_i, rst_ni,
                  ctrl_i.accept && empty && cmd_i[1],
                  (status_q == ST_EMPTY) && !pop_ok_q,
                  "pop on an empty deque was not refused")

endmodule
